@@ design/lab_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lab_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_UP_X = 2'd0;
	localparam logic [1:0] REG_UP_Y = 2'd1;
	localparam logic [1:0] REG_UP_Z = 2'd2;

	localparam logic signed [15:0] UP_X_RESET = 16'sd0;
	localparam logic signed [15:0] UP_Y_RESET = 16'sd0;
	localparam logic signed [15:0] UP_Z_RESET = 16'sd16384;

	// reduced vector: magnitudes with the largest in [2^29, 2^30)
	typedef struct packed {
		logic [2:0][29:0] mag;
		logic [2:0]       neg;
		logic             nz;
	} red_t;

	// unit vector in Q1.14
	typedef struct packed {
		logic [2:0][15:0] q;
		logic             nz;
	} uvec_t;

	typedef struct packed {
		logic signed [31:0] src_x;
		logic signed [31:0] src_y;
		logic signed [31:0] src_z;
		logic signed [31:0] dst_x;
		logic signed [31:0] dst_y;
		logic signed [31:0] dst_z;
	} in_t;

	typedef struct packed {
		logic signed [15:0] side_x;
		logic signed [15:0] side_y;
		logic signed [15:0] side_z;
		logic signed [15:0] upv_x;
		logic signed [15:0] upv_y;
		logic signed [15:0] upv_z;
		logic signed [15:0] back_x;
		logic signed [15:0] back_y;
		logic signed [15:0] back_z;
		logic               degenerate;
	} out_t;

endpackage

`default_nettype wire

@@ design/lab_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lab_in_if import lab_pkg::*; ();
	logic valid;
	logic ready;
	in_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lab_out_if import lab_pkg::*; ();
	logic valid;
	logic ready;
	out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lab_cfg_if ();
	logic        valid;
	logic        ready;
	logic [1:0]  idx;
	logic [15:0] data;
	modport source (output valid, output idx, output data, input ready);
	modport sink (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

@@ design/look_at_basis_top.sv @@
// Throughput: one item per cycle while the output is not stalled; depth
// is set by the 31-stage square root and the 15-stage divider inside
// each normalize unit, the second cross product waiting on the reduced
// side and forward vectors.
// Reset: asynchronous, clears all stage valid bits and sets up = (0, 0, 1.0).
`timescale 1ns / 1ps
`default_nettype none

module look_at_basis_top import lab_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lab_in_if.sink    pos,
	lab_out_if.source basis,
	lab_cfg_if.sink   cfg
);

	localparam int DEPTH = 64;

	logic signed [15:0] up_q [3];
	logic               vld_s [1:DEPTH];
	logic               en;

	assign en        = !vld_s[DEPTH] || basis.ready;
	assign pos.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q[0] <= UP_X_RESET;
			up_q[1] <= UP_Y_RESET;
			up_q[2] <= UP_Z_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.idx)
				REG_UP_X: up_q[0] <= cfg.data;
				REG_UP_Y: up_q[1] <= cfg.data;
				REG_UP_Z: up_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= DEPTH; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= pos.valid;
			for (int i = 2; i <= DEPTH; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// forward = target - source, then f x up
	logic signed [32:0] f_s1 [3], f_s2 [3], f_s3 [3];
	logic signed [48:0] p_s2 [6];
	logic signed [49:0] s_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1[0] <= {pos.data.dst_x[31], pos.data.dst_x} - {pos.data.src_x[31], pos.data.src_x};
			f_s1[1] <= {pos.data.dst_y[31], pos.data.dst_y} - {pos.data.src_y[31], pos.data.src_y};
			f_s1[2] <= {pos.data.dst_z[31], pos.data.dst_z} - {pos.data.src_z[31], pos.data.src_z};
			p_s2[0] <= f_s1[1] * up_q[2];
			p_s2[1] <= f_s1[2] * up_q[1];
			p_s2[2] <= f_s1[2] * up_q[0];
			p_s2[3] <= f_s1[0] * up_q[2];
			p_s2[4] <= f_s1[0] * up_q[1];
			p_s2[5] <= f_s1[1] * up_q[0];
			f_s2    <= f_s1;
			s_s3[0] <= p_s2[0] - p_s2[1];
			s_s3[1] <= p_s2[2] - p_s2[3];
			s_s3[2] <= p_s2[4] - p_s2[5];
			f_s3    <= f_s2;
		end
	end

	logic [2:0][63:0] fvec, svec, uvec;
	red_t             f_red, s_red, u_red;
	uvec_t            f_res, s_res, u_res;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fvec[i] = {{31{f_s3[i][32]}}, f_s3[i]};
			svec[i] = {{14{s_s3[i][49]}}, s_s3[i]};
		end
	end

	lab_unit u_fwd (.clk(clk), .en(en), .vec(fvec), .red(f_red), .res(f_res));
	lab_unit u_side (.clk(clk), .en(en), .vec(svec), .red(s_red), .res(s_res));

	// second cross product on the reduced signed side and forward vectors
	logic signed [30:0] sr [3], fr [3];
	logic signed [61:0] up_s8 [6];
	logic signed [62:0] u_s9 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sr[i] = s_red.neg[i] ? -$signed({1'b0, s_red.mag[i]}) : $signed({1'b0, s_red.mag[i]});
			fr[i] = f_red.neg[i] ? -$signed({1'b0, f_red.mag[i]}) : $signed({1'b0, f_red.mag[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			up_s8[0] <= sr[1] * fr[2];
			up_s8[1] <= sr[2] * fr[1];
			up_s8[2] <= sr[2] * fr[0];
			up_s8[3] <= sr[0] * fr[2];
			up_s8[4] <= sr[0] * fr[1];
			up_s8[5] <= sr[1] * fr[0];
			u_s9[0]  <= up_s8[0] - up_s8[1];
			u_s9[1]  <= up_s8[2] - up_s8[3];
			u_s9[2]  <= up_s8[4] - up_s8[5];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) uvec[i] = {u_s9[i][62], u_s9[i]};
	end

	lab_unit u_upv (.clk(clk), .en(en), .vec(uvec), .red(u_red), .res(u_res));

	// align forward and side results with the up path
	uvec_t fd_s [1:6];
	uvec_t sd_s [1:6];
	out_t  out_s64;

	always_ff @(posedge clk) begin
		if (en) begin
			fd_s[1] <= f_res;
			sd_s[1] <= s_res;
			for (int i = 2; i <= 6; i++) begin
				fd_s[i] <= fd_s[i-1];
				sd_s[i] <= sd_s[i-1];
			end
			out_s64.side_x     <= sd_s[6].q[0];
			out_s64.side_y     <= sd_s[6].q[1];
			out_s64.side_z     <= sd_s[6].q[2];
			out_s64.upv_x      <= u_res.q[0];
			out_s64.upv_y      <= u_res.q[1];
			out_s64.upv_z      <= u_res.q[2];
			out_s64.back_x     <= 16'd0 - fd_s[6].q[0];
			out_s64.back_y     <= 16'd0 - fd_s[6].q[1];
			out_s64.back_z     <= 16'd0 - fd_s[6].q[2];
			out_s64.degenerate <= !(fd_s[6].nz && sd_s[6].nz && u_res.nz);
		end
	end

	assign basis.valid = vld_s[DEPTH];
	assign basis.data  = out_s64;

endmodule

`default_nettype wire

@@ design/lab_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pipelined normalize: magnitude/sign, 3-stage shift normalize, squares,
// sum, 31-stage square root, 15-stage restoring divide, sign restore.
module lab_unit import lab_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [2:0][63:0] vec,
	output red_t             red,
	output uvec_t            res
);

	function automatic logic [2:0][63:0] norm_step(input logic [2:0][63:0] m, input int k);
		logic [63:0]      o;
		logic [2:0][63:0] r;
		o = m[0] | m[1] | m[2];
		for (int i = 0; i < 3; i++) begin
			r[i] = ((o >> (64 - k)) == 64'd0) ? (m[i] << k) : m[i];
		end
		return r;
	endfunction

	logic [2:0][63:0] mag_s1, nrm_s2, nrm_s3, nrm_s4;
	logic [2:0]       neg_s1, neg_s2, neg_s3, neg_s4;
	logic             nz_s1, nz_s2, nz_s3, nz_s4;
	logic [2:0][59:0] sq_s5;
	red_t             rd_s5;

	logic [61:0] x_s  [0:31];
	logic [61:0] r_s  [0:31];
	red_t        rs_s [0:31];

	logic [2:0][44:0] nm_s  [0:15];
	logic [2:0][30:0] rem_s [0:15];
	logic [2:0][14:0] q_s   [0:15];
	logic [30:0]      len_s [0:15];
	red_t             rd_s  [0:15];

	uvec_t res_q;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec[i][63];
				mag_s1[i] <= vec[i][63] ? (64'd0 - vec[i]) : vec[i];
			end
			nz_s1 <= |(vec[0] | vec[1] | vec[2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_s2 <= norm_step(norm_step(mag_s1, 32), 16);
			nrm_s3 <= norm_step(norm_step(nrm_s2, 8), 4);
			nrm_s4 <= norm_step(norm_step(nrm_s3, 2), 1);
			neg_s2 <= neg_s1;
			neg_s3 <= neg_s2;
			neg_s4 <= neg_s3;
			nz_s2  <= nz_s1;
			nz_s3  <= nz_s2;
			nz_s4  <= nz_s3;
		end
	end

	// msb of the largest magnitude now sits at bit 63
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			red.mag[i] = nrm_s4[i][63:34];
		end
		red.neg = neg_s4;
		red.nz  = nz_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= red.mag[i] * red.mag[i];
			end
			rd_s5 <= red;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= {2'b00, sq_s5[0]} + {2'b00, sq_s5[1]} + {2'b00, sq_s5[2]};
			r_s[0]  <= 62'd0;
			rs_s[0] <= rd_s5;
		end
	end

	for (genvar k = 1; k <= 31; k++) begin : g_sqrt
		logic [61:0] bitv;
		logic [62:0] t;
		assign bitv = 62'd1 << (62 - 2 * k);
		assign t    = {1'b0, r_s[k-1]} + {1'b0, bitv};
		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, x_s[k-1]} >= t) begin
					x_s[k] <= x_s[k-1] - t[61:0];
					r_s[k] <= (r_s[k-1] >> 1) + bitv;
				end else begin
					x_s[k] <= x_s[k-1];
					r_s[k] <= r_s[k-1] >> 1;
				end
				rs_s[k] <= rs_s[k-1];
			end
		end
	end

	// numerator mag * 2^14 + len / 2, rounding half up
	logic [30:0]      len_c;
	logic [2:0][44:0] nm_c;
	always_comb begin
		len_c = r_s[31][30:0];
		for (int i = 0; i < 3; i++) begin
			nm_c[i] = {1'b0, rs_s[31].mag[i], 14'd0} + {15'd0, len_c[30:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nm_s[0] <= nm_c;
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= {1'b0, nm_c[i][44:15]};
			end
			q_s[0]   <= '0;
			len_s[0] <= len_c;
			rd_s[0]  <= rs_s[31];
		end
	end

	for (genvar j = 1; j <= 15; j++) begin : g_div
		logic [2:0][31:0] t;
		logic [2:0]       ge;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				t[i]  = {rem_s[j-1][i], nm_s[j-1][i][15-j]};
				ge[i] = t[i] >= {1'b0, len_s[j-1]};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					rem_s[j][i] <= ge[i] ? 31'(t[i] - {1'b0, len_s[j-1]}) : t[i][30:0];
					q_s[j][i]   <= {q_s[j-1][i][13:0], ge[i]};
				end
				nm_s[j]  <= nm_s[j-1];
				len_s[j] <= len_s[j-1];
				rd_s[j]  <= rd_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (!rd_s[15].nz) begin
					res_q.q[i] <= 16'd0;
				end else if (rd_s[15].neg[i]) begin
					res_q.q[i] <= 16'd0 - {1'b0, q_s[15][i]};
				end else begin
					res_q.q[i] <= {1'b0, q_s[15][i]};
				end
			end
			res_q.nz <= rd_s[15].nz;
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

@@ design/lab_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lab_chk import lab_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	logic back_zero, side_zero;
	assign back_zero = (out_data.back_x == 16'sd0) && (out_data.back_y == 16'sd0)
		&& (out_data.back_z == 16'sd0);
	assign side_zero = (out_data.side_x == 16'sd0) && (out_data.side_y == 16'sd0)
		&& (out_data.side_z == 16'sd0);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.back_x >= -16'sd16384 && out_data.back_x <= 16'sd16384
			&& out_data.side_x >= -16'sd16384 && out_data.side_x <= 16'sd16384
			&& out_data.upv_z >= -16'sd16384 && out_data.upv_z <= 16'sd16384)
		else $error("unit component out of range");

	a_nondeg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.degenerate |-> !back_zero && !side_zero)
		else $error("zero vector without degenerate flag");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (back_zero || side_zero) |-> out_data.degenerate)
		else $error("zero vector left unflagged");

endmodule

bind look_at_basis_top lab_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(basis.valid),
	.out_ready(basis.ready),
	.out_data(basis.data)
);

`default_nettype wire
